// File: hdl/spq_pkg.sv
`default_nettype none

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OUT_CNT_W = 5;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} spq_cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic                     mode;
		logic signed [DATA_W-1:0] data;
	} spq_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/spq_cell.sv
`default_nettype none

module spq_cell (
	input  wire logic                               clk,
	input  wire spq_pkg::spq_ctrl_t                 ctrl,
	input  wire logic                               valid,
	input  wire logic                               hit_in,
	input  wire logic signed [spq_pkg::DATA_W-1:0]  left_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0]  right_value,
	output logic                                    hit_out,
	output logic signed [spq_pkg::DATA_W-1:0]       value,
	output logic signed [spq_pkg::DATA_W-1:0]       value_next
);

	logic signed [spq_pkg::DATA_W-1:0] value_q;
	logic precedes;
	logic my_hit;

	assign precedes = ctrl.mode ? (ctrl.data > value_q) : (ctrl.data < value_q);
	// an empty slot always takes the new value if nothing earlier did
	assign my_hit = !valid || precedes;
	assign hit_out = hit_in || my_hit;

	always_comb begin
		value_next = value_q;
		if (ctrl.ins) begin
			if (hit_in) begin
				value_next = left_value;
			end else if (my_hit) begin
				value_next = ctrl.data;
			end
		end else if (ctrl.rem) begin
			value_next = right_value;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_next;
	end

	assign value = value_q;

endmodule

`default_nettype wire

// File: hdl/sorted_priority_queue.sv
// sorted priority queue, up to spq_pkg::DEPTH signed 32-bit entries
// requests come in on in_valid/in_stall with command (0 insert, 1 remove) and
// value; one result per request leaves on out_valid/out_stall carrying
// removed_value, front_value, entry_count and status
// entries live in a row of cells; every cell compares the new value against
// its own entry at once and an insert ripples a shift right from the first
// cell the value should precede, a remove shifts the whole row left
// the result is registered: it is in the output register the cycle after
// the request is taken, and one request per cycle is taken while the result
// side keeps up
// when the receiver stalls with a result pending, in_stall goes high until
// that result is taken; the queue state does not move meanwhile
// order_mode is to be written with cfg_wr_en/cfg_wr_data only while the block
// is idle, which the block itself does not enforce; stored entries keep their
// order across a mode change; reset empties the queue and selects min-first
// order; there is no clearing pass, so requests are taken right after reset
`default_nettype none

module sorted_priority_queue (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic                                  cfg_wr_data,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  command,
	input  wire logic signed [spq_pkg::DATA_W-1:0]     value,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [spq_pkg::DATA_W-1:0]          removed_value,
	output logic signed [spq_pkg::DATA_W-1:0]          front_value,
	output logic [spq_pkg::OUT_CNT_W-1:0]              entry_count,
	output logic [1:0]                                 status
);

	localparam int N = spq_pkg::DEPTH;

	logic                          mode_q;
	logic [spq_pkg::CNT_W-1:0]     count_q;
	logic [spq_pkg::CNT_W-1:0]     count_next;
	logic                          out_valid_q;
	logic signed [spq_pkg::DATA_W-1:0] removed_q;
	logic signed [spq_pkg::DATA_W-1:0] front_q;
	logic [spq_pkg::OUT_CNT_W-1:0] entry_count_q;
	spq_pkg::spq_status_t          status_q;

	logic accept;
	logic is_full;
	logic is_empty;
	logic do_ins;
	logic do_rem;
	spq_pkg::spq_status_t st_next;
	spq_pkg::spq_ctrl_t   ctrl;

	logic [N-1:0] valid_vec;
	logic [N:0]   hit;
	logic signed [spq_pkg::DATA_W-1:0] cell_val [N];
	logic signed [spq_pkg::DATA_W-1:0] cell_nxt [N];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign is_full  = (count_q == spq_pkg::CNT_W'(N));
	assign is_empty = (count_q == '0);
	assign do_ins   = accept && (command == spq_pkg::CMD_INSERT) && !is_full;
	assign do_rem   = accept && (command == spq_pkg::CMD_REMOVE) && !is_empty;

	assign ctrl.ins  = do_ins;
	assign ctrl.rem  = do_rem;
	assign ctrl.mode = mode_q;
	assign ctrl.data = value;

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic signed [spq_pkg::DATA_W-1:0] left_v;
		logic signed [spq_pkg::DATA_W-1:0] right_v;

		assign valid_vec[i] = (spq_pkg::CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_v = value;
		end else begin : g_mid
			assign left_v = cell_val[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.valid       (valid_vec[i]),
			.hit_in      (hit[i]),
			.left_value  (left_v),
			.right_value (right_v),
			.hit_out     (hit[i+1]),
			.value       (cell_val[i]),
			.value_next  (cell_nxt[i])
		);
	end

	always_comb begin
		count_next = count_q;
		st_next    = spq_pkg::ST_DONE;
		if (command == spq_pkg::CMD_INSERT) begin
			if (is_full) begin
				st_next = spq_pkg::ST_FULL;
			end else begin
				count_next = count_q + spq_pkg::CNT_W'(1);
			end
		end else begin
			if (is_empty) begin
				st_next = spq_pkg::ST_EMPTY;
			end else begin
				count_next = count_q - spq_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (accept) begin
				count_q <= count_next;
			end
			out_valid_q <= accept || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q     <= do_rem ? cell_val[0] : '0;
			front_q       <= (count_next != '0) ? cell_nxt[0] : '0;
			entry_count_q <= spq_pkg::OUT_CNT_W'(count_next);
			status_q      <= st_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign front_value   = front_q;
	assign entry_count   = entry_count_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(N))
		else $error("entry count above depth");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request gave no result");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == spq_pkg::CMD_INSERT) && is_full
		|=> (status_q == spq_pkg::ST_FULL) && $stable(count_q))
		else $error("insert into full queue not dropped");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == spq_pkg::CMD_REMOVE) && is_empty
		|=> (status_q == spq_pkg::ST_EMPTY) && (removed_q == '0) && (count_q == '0))
		else $error("remove from empty queue mishandled");
`endif

endmodule

`default_nettype wire
